>>> rtl/core/hpr_pkg.sv
package hpr_pkg;

    // Default widths of the coordinate and trig words.
    localparam int COORD_WIDTH_DEF = 32;
    localparam int TRIG_WIDTH_DEF  = 16;

    // Configuration register index width and codes.
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_HEADING = 3'd0,
        REG_SIN_HEADING = 3'd1,
        REG_COS_PITCH   = 3'd2,
        REG_SIN_PITCH   = 3'd3,
        REG_COS_ROLL    = 3'd4,
        REG_SIN_ROLL    = 3'd5
    } t_cfg_reg;

    // Slots of the angle arrays handed from the register file to the stages.
    localparam int ANG_HEADING = 0;
    localparam int ANG_PITCH   = 1;
    localparam int ANG_ROLL    = 2;
    localparam int ANG_COUNT   = 3;

    // Coordinate slots inside the six-word payload: position then normal.
    localparam int AX_X = 0;
    localparam int AX_Y = 1;
    localparam int AX_Z = 2;
    localparam int VEC_WORDS = 6;

endpackage

>>> rtl/core/hpr_vtx_in_if.sv
interface hpr_vtx_in_if #(
    parameter int COORD_WIDTH = hpr_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] pos_x;
    logic signed [COORD_WIDTH-1:0] pos_y;
    logic signed [COORD_WIDTH-1:0] pos_z;
    logic signed [COORD_WIDTH-1:0] norm_x;
    logic signed [COORD_WIDTH-1:0] norm_y;
    logic signed [COORD_WIDTH-1:0] norm_z;

    modport source (
        output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        input  ready
    );
    modport sink (
        input  valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
        output ready
    );
endinterface

>>> rtl/core/hpr_vtx_out_if.sv
interface hpr_vtx_out_if #(
    parameter int COORD_WIDTH = hpr_pkg::COORD_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] rot_pos_x;
    logic signed [COORD_WIDTH-1:0] rot_pos_y;
    logic signed [COORD_WIDTH-1:0] rot_pos_z;
    logic signed [COORD_WIDTH-1:0] rot_norm_x;
    logic signed [COORD_WIDTH-1:0] rot_norm_y;
    logic signed [COORD_WIDTH-1:0] rot_norm_z;

    modport source (
        output valid, rot_pos_x, rot_pos_y, rot_pos_z,
               rot_norm_x, rot_norm_y, rot_norm_z,
        input  ready
    );
    modport sink (
        input  valid, rot_pos_x, rot_pos_y, rot_pos_z,
               rot_norm_x, rot_norm_y, rot_norm_z,
        output ready
    );
endinterface

>>> rtl/core/hpr_cfg_if.sv
interface hpr_cfg_if #(
    parameter int TRIG_WIDTH = hpr_pkg::TRIG_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic [hpr_pkg::CFG_IDX_W-1:0] index;
    logic [TRIG_WIDTH-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/hpr_cfg_regs.sv
module hpr_cfg_regs #(
    parameter int TRIG_WIDTH = hpr_pkg::TRIG_WIDTH_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_ready,
    input  hpr_pkg::t_cfg_idx                         i_index,
    input  logic [TRIG_WIDTH-1:0]                     i_data,
    output logic [hpr_pkg::ANG_COUNT-1:0][TRIG_WIDTH-1:0] o_cos,
    output logic [hpr_pkg::ANG_COUNT-1:0][TRIG_WIDTH-1:0] o_sin
);
    import hpr_pkg::*;

    // Unity in Q2.(TRIG_WIDTH-2).
    localparam logic [TRIG_WIDTH-1:0] TRIG_ONE = {2'b01, {(TRIG_WIDTH-2){1'b0}}};

    logic [ANG_COUNT-1:0][TRIG_WIDTH-1:0] r_cos;
    logic [ANG_COUNT-1:0][TRIG_WIDTH-1:0] r_sin;

    assign o_ready = 1'b1;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int a = 0; a < ANG_COUNT; a++) begin
                r_cos[a] <= TRIG_ONE;
                r_sin[a] <= '0;
            end
        end else if (i_valid) begin
            unique case (i_index)
                REG_COS_HEADING: r_cos[ANG_HEADING] <= i_data;
                REG_SIN_HEADING: r_sin[ANG_HEADING] <= i_data;
                REG_COS_PITCH:   r_cos[ANG_PITCH]   <= i_data;
                REG_SIN_PITCH:   r_sin[ANG_PITCH]   <= i_data;
                REG_COS_ROLL:    r_cos[ANG_ROLL]    <= i_data;
                REG_SIN_ROLL:    r_sin[ANG_ROLL]    <= i_data;
                default: ;
            endcase
        end
    end

endmodule

>>> rtl/core/hpr_rot_stage.sv
module hpr_rot_stage #(
    parameter int COORD_WIDTH = hpr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = hpr_pkg::TRIG_WIDTH_DEF,
    parameter int AXIS_P      = hpr_pkg::AX_X,
    parameter int AXIS_Q      = hpr_pkg::AX_Z,
    parameter bit NEG_P       = 1'b0
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [hpr_pkg::VEC_WORDS-1:0][COORD_WIDTH-1:0] i_data,
    input  logic [TRIG_WIDTH-1:0]                          i_cos,
    input  logic [TRIG_WIDTH-1:0]                          i_sin,
    output logic                                           o_valid,
    input  logic                                           i_ready,
    output logic [hpr_pkg::VEC_WORDS-1:0][COORD_WIDTH-1:0] o_data
);
    import hpr_pkg::*;

    // p' = p*c + q*sp and q' = q*c + p*sq, with sp = -sq = +/-sin.
    localparam int AXIS_R = 3 - AXIS_P - AXIS_Q;
    localparam int PW     = COORD_WIDTH + TRIG_WIDTH + 1;
    localparam int SW     = PW + 1;
    localparam int FB     = TRIG_WIDTH - 2;
    localparam int RW     = SW - FB;
    localparam logic signed [SW-1:0] RND = SW'(1) << (FB - 1);

    function automatic logic [COORD_WIDTH-1:0] sat(input logic signed [RW-1:0] v);
        logic [RW-COORD_WIDTH:0] top;
        top = v[RW-1:COORD_WIDTH-1];
        if ((&top) || !(|top)) begin
            return v[COORD_WIDTH-1:0];
        end else if (v[RW-1]) begin
            return {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            return {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    endfunction

    logic signed [TRIG_WIDTH:0] cos_e;
    logic signed [TRIG_WIDTH:0] sin_e;
    logic signed [TRIG_WIDTH:0] sin_n;
    logic signed [TRIG_WIDTH:0] sin_p;
    logic signed [TRIG_WIDTH:0] sin_q;

    logic en_a;
    logic en_b;
    logic r_va;
    logic r_vb;

    logic signed [PW-1:0]   r_pc   [2];
    logic signed [PW-1:0]   r_qs   [2];
    logic signed [PW-1:0]   r_qc   [2];
    logic signed [PW-1:0]   r_ps   [2];
    logic [COORD_WIDTH-1:0] r_pass [2];

    logic signed [SW-1:0] sum_p [2];
    logic signed [SW-1:0] sum_q [2];
    logic signed [RW-1:0] sh_p  [2];
    logic signed [RW-1:0] sh_q  [2];

    logic [VEC_WORDS-1:0][COORD_WIDTH-1:0] r_out;

    assign cos_e = {i_cos[TRIG_WIDTH-1], i_cos};
    assign sin_e = {i_sin[TRIG_WIDTH-1], i_sin};
    assign sin_n = -sin_e;
    assign sin_p = NEG_P ? sin_n : sin_e;
    assign sin_q = NEG_P ? sin_e : sin_n;

    // A register level takes a new beat when it is empty or its beat moves on.
    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    // Level A: the four products of each vector.
    always_ff @(posedge i_clk) begin
        if (en_a) begin
            for (int k = 0; k < 2; k++) begin
                r_pc[k]   <= PW'($signed(i_data[3*k+AXIS_P])) * PW'(cos_e);
                r_qs[k]   <= PW'($signed(i_data[3*k+AXIS_Q])) * PW'(sin_p);
                r_qc[k]   <= PW'($signed(i_data[3*k+AXIS_Q])) * PW'(cos_e);
                r_ps[k]   <= PW'($signed(i_data[3*k+AXIS_P])) * PW'(sin_q);
                r_pass[k] <= i_data[3*k+AXIS_R];
            end
        end
    end

    // Level B: sum, round half up, drop the fraction and clamp.
    always_comb begin
        for (int k = 0; k < 2; k++) begin
            sum_p[k] = SW'(r_pc[k]) + SW'(r_qs[k]) + RND;
            sum_q[k] = SW'(r_qc[k]) + SW'(r_ps[k]) + RND;
            sh_p[k]  = RW'(sum_p[k] >>> FB);
            sh_q[k]  = RW'(sum_q[k] >>> FB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            for (int k = 0; k < 2; k++) begin
                r_out[3*k+AXIS_P] <= sat(sh_p[k]);
                r_out[3*k+AXIS_Q] <= sat(sh_q[k]);
                r_out[3*k+AXIS_R] <= r_pass[k];
            end
        end
    end

endmodule

>>> rtl/core/hpr_rotate_vertex_normal.sv
// Channel   Direction  Beat contents
// i_vtx     in         pos_x/y/z, norm_x/y/z: signed Q16.16 vertex and normal
// o_vtx     out        rot_pos_x/y/z, rot_norm_x/y/z: rotated, saturated
// i_cfg     in         index (0..5, others ignored) and data: one cos/sin register in Q2.14
//
// One beat is accepted every cycle while results drain. Each rotation registers a beat in
// a multiplier level and then a round/clamp level; a stalled o_vtx holds beats back in
// those levels.
// Reset clears every valid bit and loads the identity rotation (cos one, sin 0).
// When o_vtx is stalled, the pipeline keeps moving into its empty levels and
// i_vtx.ready drops only once every level holds a beat.
module hpr_rotate_vertex_normal #(
    parameter int COORD_WIDTH = hpr_pkg::COORD_WIDTH_DEF,
    parameter int TRIG_WIDTH  = hpr_pkg::TRIG_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    hpr_vtx_in_if.sink    i_vtx,
    hpr_vtx_out_if.source o_vtx,
    hpr_cfg_if.sink       i_cfg
);
    import hpr_pkg::*;

    // Trig values for heading, pitch and roll from the register file.
    logic [ANG_COUNT-1:0][TRIG_WIDTH-1:0] cos_a;
    logic [ANG_COUNT-1:0][TRIG_WIDTH-1:0] sin_a;

    // Payload between stages: position words first, then the normal.
    logic [VEC_WORDS-1:0][COORD_WIDTH-1:0] in_data;
    logic [VEC_WORDS-1:0][COORD_WIDTH-1:0] roll_data;
    logic [VEC_WORDS-1:0][COORD_WIDTH-1:0] pitch_data;
    logic [VEC_WORDS-1:0][COORD_WIDTH-1:0] head_data;

    logic roll_valid;
    logic roll_ready;
    logic pitch_valid;
    logic pitch_ready;

    hpr_cfg_regs #(
        .TRIG_WIDTH (TRIG_WIDTH)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg.valid),
        .o_ready (i_cfg.ready),
        .i_index (i_cfg.index),
        .i_data  (i_cfg.data),
        .o_cos   (cos_a),
        .o_sin   (sin_a)
    );

    assign in_data[AX_X]     = i_vtx.pos_x;
    assign in_data[AX_Y]     = i_vtx.pos_y;
    assign in_data[AX_Z]     = i_vtx.pos_z;
    assign in_data[3 + AX_X] = i_vtx.norm_x;
    assign in_data[3 + AX_Y] = i_vtx.norm_y;
    assign in_data[3 + AX_Z] = i_vtx.norm_z;

    // Roll about y: x' = x*c + z*s, z' = z*c - x*s.
    hpr_rot_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH),
        .AXIS_P      (AX_X),
        .AXIS_Q      (AX_Z),
        .NEG_P       (1'b0)
    ) u_roll (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_vtx.valid),
        .o_ready (i_vtx.ready),
        .i_data  (in_data),
        .i_cos   (cos_a[ANG_ROLL]),
        .i_sin   (sin_a[ANG_ROLL]),
        .o_valid (roll_valid),
        .i_ready (roll_ready),
        .o_data  (roll_data)
    );

    // Pitch about x: y' = y*c - z*s, z' = z*c + y*s.
    hpr_rot_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH),
        .AXIS_P      (AX_Y),
        .AXIS_Q      (AX_Z),
        .NEG_P       (1'b1)
    ) u_pitch (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (roll_valid),
        .o_ready (roll_ready),
        .i_data  (roll_data),
        .i_cos   (cos_a[ANG_PITCH]),
        .i_sin   (sin_a[ANG_PITCH]),
        .o_valid (pitch_valid),
        .i_ready (pitch_ready),
        .o_data  (pitch_data)
    );

    // Heading about z: x' = x*c - y*s, y' = y*c + x*s.
    hpr_rot_stage #(
        .COORD_WIDTH (COORD_WIDTH),
        .TRIG_WIDTH  (TRIG_WIDTH),
        .AXIS_P      (AX_X),
        .AXIS_Q      (AX_Y),
        .NEG_P       (1'b1)
    ) u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pitch_valid),
        .o_ready (pitch_ready),
        .i_data  (pitch_data),
        .i_cos   (cos_a[ANG_HEADING]),
        .i_sin   (sin_a[ANG_HEADING]),
        .o_valid (o_vtx.valid),
        .i_ready (o_vtx.ready),
        .o_data  (head_data)
    );

    // The last stage's output register drives the result channel directly.
    assign o_vtx.rot_pos_x  = head_data[AX_X];
    assign o_vtx.rot_pos_y  = head_data[AX_Y];
    assign o_vtx.rot_pos_z  = head_data[AX_Z];
    assign o_vtx.rot_norm_x = head_data[3 + AX_X];
    assign o_vtx.rot_norm_y = head_data[3 + AX_Y];
    assign o_vtx.rot_norm_z = head_data[3 + AX_Z];

    // Back-pressure reaches the input only when the result side is stalled.
    a_ready_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_vtx.ready |-> (o_vtx.valid && !o_vtx.ready))
        else $error("input stalled while the result side is not stalled");

    // Reset clears the valid bits, so nothing leaves right after reset.
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_vtx.valid)
        else $error("result valid in the cycle after reset");

    // Only the last stage holding a beat can keep the middle stage from draining.
    a_chain_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pitch_ready |-> (o_vtx.valid && !o_vtx.ready))
        else $error("pitch stage stalled without a stalled result");

endmodule
